// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the heightmap RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/hcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hcd_pkg
// Types, constants and the bump shape function for the heightmap core.
// ----------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

	localparam int DEF_GRID_X         = 256;
	localparam int DEF_GRID_Z         = 256;
	localparam int DEF_COS_TABLE_BITS = 8;

	localparam int KIND_W   = 2;
	localparam int COORD_W  = 8;
	localparam int RADIUS_W = 6;
	localparam int DISP_W   = 4;
	localparam int HEIGHT_W = 24;
	localparam int R2_W     = 2 * RADIUS_W;
	localparam int BUMP_W   = 17;

	localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [COORD_W-1:0]  center_x;
		logic [COORD_W-1:0]  center_z;
		logic [RADIUS_W-1:0] radius;
		logic [DISP_W-1:0]   displacement;
		logic [COORD_W-1:0]  read_x;
		logic [COORD_W-1:0]  read_z;
	} hcd_req_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height_value;
		logic [HEIGHT_W-1:0] max_height;
	} hcd_rsp_t;

	typedef struct packed {
		logic              busy;
		logic              valid;
		logic              hit;
		logic [BUMP_W-1:0] shape;
	} hcd_pipe_stat_t;

	// Q1.16 bump shape (1+cos)/2 squared-cosine form, evaluated at elaboration
	function automatic logic [BUMP_W-1:0] hcd_bump_entry(input int k, input int bits);
		longint unsigned v;
		longint unsigned res;
		longint unsigned bitv;
		longint unsigned h;
		longint unsigned h2;
		longint unsigned t;
		longint unsigned p;
		longint unsigned sq;
		int n;
		v = 64'(k) << (32 - bits);
		res = 64'd0;
		bitv = 64'h4000_0000_0000_0000;
		for (n = 0; n < 32; n++) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		h = (res * 64'd314 * 64'd8192 + 64'd50) / 64'd100;
		h2 = (h * h) >> 30;
		t = Q30_ONE;
		p = ((h2 * t) >> 30) / 64'd132;
		t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((h2 * t) >> 30) / 64'd90;
		t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((h2 * t) >> 30) / 64'd56;
		t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((h2 * t) >> 30) / 64'd30;
		t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((h2 * t) >> 30) / 64'd12;
		t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		p = ((h2 * t) >> 30) / 64'd2;
		t = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
		sq = (t * t) >> 30;
		return BUMP_W'((sq + 64'd8192) >> 14);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/heightmap_circle_displacement_core.sv =====
// ----------------------------------------------------------------------------
// heightmap_circle_displacement_core
// Circle-displacement terrain heightmap held in one RAM, with running maximum.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready); each one yields exactly one response
// on rsp (valid/ready) carrying the read height and the maximum height.
// One request is worked on at a time; req_ready is high only while idle.
// A circle request sweeps every cell once, one cell per cycle, through a
// read-modify-write pipeline on the heightmap RAM; the sweep is followed
// by a drain of the pipeline, and then the response is loaded.
// Each cell passes the single RAM read port and, inside the circle, the
// single RAM write port. A clear request writes zero to every cell.
// A read request reads one cell from the RAM; an unused kind goes
// straight to the response.
// After reset the RAM is wiped, one cell per cycle, before the first
// request is taken.
// The response sits in an output register: a new request is taken while it
// waits, and that request's own response is held back until rsp is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module heightmap_circle_displacement_core #(
	parameter int GRID_X         = hcd_pkg::DEF_GRID_X,
	parameter int GRID_Z         = hcd_pkg::DEF_GRID_Z,
	parameter int COS_TABLE_BITS = hcd_pkg::DEF_COS_TABLE_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire hcd_pkg::hcd_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output hcd_pkg::hcd_rsp_t      rsp
);

	import hcd_pkg::*;

	localparam int DEPTH = GRID_X * GRID_Z;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(GRID_X);
	localparam int ZW    = $clog2(GRID_Z);
	localparam int PW    = BUMP_W + DISP_W;
	localparam int IW    = PW + 1 - 8;

	typedef enum logic [5:0] {
		ST_WIPE  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_SWEEP = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_READ  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [AW-1:0]       addr_q;
	logic [XW-1:0]       i_q;
	logic [ZW-1:0]       j_q;
	logic                pend_q;
	logic [HEIGHT_W-1:0] max_q;
	logic [HEIGHT_W-1:0] hv_q;
	logic                in_range_q;
	logic [COORD_W-1:0]  cx_q;
	logic [COORD_W-1:0]  cz_q;
	logic [R2_W-1:0]     r2_q;
	logic [DISP_W-1:0]   disp_q;

	logic              rmw_valid_s1;
	logic              rmw_hit_s1;
	logic [AW-1:0]     rmw_addr_s1;
	logic [BUMP_W-1:0] rmw_shape_s1;

	hcd_pipe_stat_t pipe_stat;
	logic [AW-1:0]  pipe_addr;

	logic                req_fire;
	logic                rsp_load;
	logic                sweep_last;
	logic [AW-1:0]       req_addr;
	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	logic [HEIGHT_W-1:0] ram_wr_data;
	logic                ram_rd_en;
	logic [AW-1:0]       ram_rd_addr;
	logic [HEIGHT_W-1:0] ram_rd_data;
	logic [PW-1:0]       prod;
	logic [PW:0]         prod_rnd;
	logic [IW-1:0]       inc;
	logic [HEIGHT_W:0]   sum;
	logic [HEIGHT_W-1:0] sat;
	logic [HEIGHT_W-1:0] cell_new;

	assign req_ready  = (state_q == ST_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid || rsp_ready);
	assign sweep_last = (addr_q == AW'(DEPTH - 1));
	assign req_addr   = AW'(32'(req.read_x) * GRID_Z + 32'(req.read_z));

	assign prod     = PW'(disp_q) * PW'(rmw_shape_s1);
	assign prod_rnd = (PW + 1)'(prod) + (PW + 1)'(128);
	assign inc      = prod_rnd[PW:8];
	assign sum      = {1'b0, ram_rd_data} + (HEIGHT_W + 1)'(inc);
	assign sat      = sum[HEIGHT_W] ? {HEIGHT_W{1'b1}} : sum[HEIGHT_W-1:0];
	assign cell_new = rmw_hit_s1 ? sat : ram_rd_data;

	assign ram_wr_en   = (state_q == ST_WIPE) || (rmw_valid_s1 && rmw_hit_s1);
	assign ram_wr_addr = (state_q == ST_WIPE) ? addr_q : rmw_addr_s1;
	assign ram_wr_data = (state_q == ST_WIPE) ? '0 : sat;
	assign ram_rd_en   = (req_fire && (req.kind == KIND_READ)) || pipe_stat.valid;
	assign ram_rd_addr = pipe_stat.valid ? pipe_addr : req_addr;

	hcd_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (DEPTH)
	) u_map (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	hcd_bump_pipe #(
		.GRID_X         (GRID_X),
		.GRID_Z         (GRID_Z),
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (state_q == ST_SWEEP),
		.cell_i     (i_q),
		.cell_j     (j_q),
		.cell_addr  (addr_q),
		.center_x   (cx_q),
		.center_z   (cz_q),
		.r2         (r2_q),
		.stat       (pipe_stat),
		.shape_addr (pipe_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_WIPE;
			addr_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			pend_q       <= 1'b0;
			max_q        <= '0;
			rsp_valid    <= 1'b0;
			rmw_valid_s1 <= 1'b0;
		end else begin
			rmw_valid_s1 <= pipe_stat.valid;
			if (rmw_valid_s1 && (cell_new > max_q)) begin
				max_q <= cell_new;
			end
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				ST_WIPE: begin
					if (sweep_last) begin
						addr_q  <= '0;
						state_q <= pend_q ? ST_DONE : ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						case (req.kind)
							KIND_CIRCLE: begin
								addr_q  <= '0;
								i_q     <= '0;
								j_q     <= '0;
								state_q <= ST_SWEEP;
							end
							KIND_READ: begin
								state_q <= ST_READ;
							end
							KIND_CLEAR: begin
								max_q   <= '0;
								pend_q  <= 1'b1;
								addr_q  <= '0;
								state_q <= ST_WIPE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					addr_q <= addr_q + 1'b1;
					if (j_q == ZW'(GRID_Z - 1)) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
					if (sweep_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_stat.busy && !rmw_valid_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			hv_q       <= '0;
			in_range_q <= (32'(req.read_x) < GRID_X) && (32'(req.read_z) < GRID_Z);
			cx_q       <= req.center_x;
			cz_q       <= req.center_z;
			r2_q       <= R2_W'(req.radius) * R2_W'(req.radius);
			disp_q     <= req.displacement;
		end
		if (state_q == ST_READ) begin
			hv_q <= in_range_q ? ram_rd_data : '0;
		end
		rmw_hit_s1   <= pipe_stat.hit;
		rmw_addr_s1  <= pipe_addr;
		rmw_shape_s1 <= pipe_stat.shape;
		if (rsp_load) begin
			rsp.height_value <= hv_q;
			rsp.max_height   <= max_q;
		end
	end

	`ASSERT_PROP(a_idle_pipe_empty, clk, arst_n, req_fire |-> (!pipe_stat.busy && !rmw_valid_s1), "request taken mid-sweep")
	`ASSERT_NEVER(a_wipe_no_rmw, clk, arst_n, (state_q == ST_WIPE) && (pipe_stat.valid || rmw_valid_s1), "update during wipe")
	`ASSERT_PROP(a_max_rises, clk, arst_n, rmw_valid_s1 |=> (max_q >= $past(max_q)), "maximum height fell")

endmodule

`default_nettype wire

// ===== rtl/hcd_ram.sv =====
// ----------------------------------------------------------------------------
// hcd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_ram #(
	parameter int WIDTH = hcd_pkg::HEIGHT_W,
	parameter int DEPTH = hcd_pkg::DEF_GRID_X * hcd_pkg::DEF_GRID_Z,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/hcd_bump_pipe.sv =====
// ----------------------------------------------------------------------------
// hcd_bump_pipe
// Per-cell pipeline: squared distance, in-circle test, table index by
// long division against radius squared, and bump shape lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module hcd_bump_pipe #(
	parameter int GRID_X         = hcd_pkg::DEF_GRID_X,
	parameter int GRID_Z         = hcd_pkg::DEF_GRID_Z,
	parameter int COS_TABLE_BITS = hcd_pkg::DEF_COS_TABLE_BITS,
	localparam int XW = $clog2(GRID_X),
	localparam int ZW = $clog2(GRID_Z),
	localparam int AW = $clog2(GRID_X * GRID_Z)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cell_valid,
	input  wire logic [XW-1:0]               cell_i,
	input  wire logic [ZW-1:0]               cell_j,
	input  wire logic [AW-1:0]               cell_addr,
	input  wire logic [hcd_pkg::COORD_W-1:0] center_x,
	input  wire logic [hcd_pkg::COORD_W-1:0] center_z,
	input  wire logic [hcd_pkg::R2_W-1:0]    r2,
	output hcd_pkg::hcd_pipe_stat_t          stat,
	output logic [AW-1:0]                    shape_addr
);

	import hcd_pkg::*;

	localparam int CW    = (XW > ZW) ? XW : ZW;
	localparam int MW    = (CW > COORD_W) ? CW : COORD_W;
	localparam int SQW   = 2 * MW;
	localparam int X4W   = SQW + 3;
	localparam int QB    = COS_TABLE_BITS + 1;
	localparam int TBL_N = 1 << COS_TABLE_BITS;

	logic [BUMP_W-1:0] bump_tbl [0:TBL_N];

	for (genvar g = 0; g <= TBL_N; g++) begin : g_tbl
		assign bump_tbl[g] = hcd_bump_entry(g, COS_TABLE_BITS);
	end

	logic          v_s1;
	logic [XW-1:0] i_s1;
	logic [ZW-1:0] j_s1;
	logic [AW-1:0] addr_s1;

	logic           v_s2;
	logic [AW-1:0]  addr_s2;
	logic [SQW-1:0] sqx_s2;
	logic [SQW-1:0] sqz_s2;

	logic            v_s3;
	logic [AW-1:0]   addr_s3;
	logic            hit_s3;
	logic [R2_W-1:0] x_s3;

	logic [QB-1:0]   div_v_s4;
	logic [QB-1:0]   div_hit_s4;
	logic [AW-1:0]   div_addr_s4 [0:QB-1];
	logic [R2_W-1:0] div_rem_s4 [0:QB-1];
	logic [QB-1:0]   div_q_s4 [0:QB-1];

	logic              v_s5;
	logic              hit_s5;
	logic [AW-1:0]     addr_s5;
	logic [BUMP_W-1:0] shape_s5;

	logic [MW-1:0]   adx;
	logic [MW-1:0]   adz;
	logic [X4W-1:0]  x4;
	logic [R2_W:0]   div_num [0:QB-1];
	logic [R2_W:0]   div_diff [0:QB-1];
	logic [QB-1:0]   div_bit;
	logic [QB-1:0]   k_raw;
	logic [QB-1:0]   k_idx;

	always_comb begin
		adx = (MW'(i_s1) >= MW'(center_x)) ? MW'(i_s1) - MW'(center_x)
			: MW'(center_x) - MW'(i_s1);
		adz = (MW'(j_s1) >= MW'(center_z)) ? MW'(j_s1) - MW'(center_z)
			: MW'(center_z) - MW'(j_s1);
		x4 = {(X4W - 2)'(sqx_s2) + (X4W - 2)'(sqz_s2), 2'b00};
	end

	always_comb begin
		for (int n = 0; n < QB; n++) begin
			if (n == 0) begin
				div_num[n] = {1'b0, x_s3};
			end else begin
				div_num[n] = {div_rem_s4[n-1], 1'b0};
			end
			div_diff[n] = div_num[n] - {1'b0, r2};
			div_bit[n] = (div_num[n] >= {1'b0, r2});
		end
	end

	assign k_raw = div_q_s4[QB-1];
	assign k_idx = (k_raw > QB'(TBL_N)) ? QB'(TBL_N) : k_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			div_v_s4 <= '0;
			v_s5     <= 1'b0;
		end else begin
			v_s1     <= cell_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			div_v_s4 <= {div_v_s4[QB-2:0], v_s3};
			v_s5     <= div_v_s4[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		i_s1    <= cell_i;
		j_s1    <= cell_j;
		addr_s1 <= cell_addr;

		addr_s2 <= addr_s1;
		sqx_s2  <= SQW'(adx) * SQW'(adx);
		sqz_s2  <= SQW'(adz) * SQW'(adz);

		addr_s3 <= addr_s2;
		hit_s3  <= (r2 != '0) && (x4 <= X4W'(r2));
		x_s3    <= x4[R2_W-1:0];

		for (int n = 0; n < QB; n++) begin
			if (n == 0) begin
				div_addr_s4[n] <= addr_s3;
				div_hit_s4[n]  <= hit_s3;
				div_q_s4[n]    <= QB'(div_bit[n]);
			end else begin
				div_addr_s4[n] <= div_addr_s4[n-1];
				div_hit_s4[n]  <= div_hit_s4[n-1];
				div_q_s4[n]    <= {div_q_s4[n-1][QB-2:0], div_bit[n]};
			end
			div_rem_s4[n] <= div_bit[n] ? div_diff[n][R2_W-1:0] : div_num[n][R2_W-1:0];
		end

		addr_s5  <= div_addr_s4[QB-1];
		hit_s5   <= div_hit_s4[QB-1];
		shape_s5 <= bump_tbl[k_idx];
	end

	assign stat.busy  = v_s1 | v_s2 | v_s3 | (|div_v_s4) | v_s5;
	assign stat.valid = v_s5;
	assign stat.hit   = hit_s5;
	assign stat.shape = shape_s5;
	assign shape_addr = addr_s5;

endmodule

`default_nettype wire
